// ===== hdl/tsb_pkg.sv =====
// tsb_pkg: types, event kinds and helpers for the indexed start/stop timer bank
// no dependencies; used by tsb_update, tsb_bank and indexed_start_stop_timer_bank
`timescale 1ns / 1ps

package tsb_pkg;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_STOP  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} tsb_kind_t;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  timer_id;
		logic [63:0] event_time;
	} tsb_req_t;

	typedef struct packed {
		logic [5:0]  timer_echo;
		logic        out_of_order;
		logic [63:0] total_time;
		logic [31:0] bad_sequence_total;
		logic [31:0] start_total;
		logic [31:0] stop_total;
		logic [31:0] clear_total;
	} tsb_rsp_t;

	// per-timer entry of the statistics memory
	typedef struct packed {
		tsb_kind_t   last_kind;
		logic [63:0] elapsed_sum;
		logic [31:0] misorder_count;
		logic [31:0] start_count;
		logic [31:0] stop_count;
		logic [31:0] clear_count;
	} tsb_stat_t;

	localparam tsb_stat_t STAT_RESET = '{
		last_kind:      KIND_NONE,
		elapsed_sum:    64'd0,
		misorder_count: 32'd0,
		start_count:    32'd0,
		stop_count:     32'd0,
		clear_count:    32'd0
	};

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

// ===== hdl/tsb_update.sv =====
// tsb_update: next-entry and result logic for one timer event
// depends on tsb_pkg
`timescale 1ns / 1ps

module tsb_update (
	input  tsb_pkg::tsb_req_t  req,
	input  logic               in_range,
	input  tsb_pkg::tsb_stat_t stat_rd,
	input  logic [63:0]        stamp_rd,
	output logic               stat_we,
	output tsb_pkg::tsb_stat_t stat_wd,
	output logic               stamp_we,
	output tsb_pkg::tsb_rsp_t  rsp
);

	logic bad;
	logic stamp_take;

	always_comb begin
		stat_wd    = stat_rd;
		bad        = 1'b0;
		stamp_take = 1'b0;
		case (req.cmd)
			tsb_pkg::KIND_START: begin
				if (stat_rd.last_kind == tsb_pkg::KIND_START) begin
					bad = 1'b1;
				end else begin
					stamp_take = 1'b1;
				end
				stat_wd.start_count = tsb_pkg::sat_inc(stat_rd.start_count);
				stat_wd.last_kind   = tsb_pkg::KIND_START;
			end
			tsb_pkg::KIND_STOP: begin
				if (stat_rd.last_kind != tsb_pkg::KIND_START) begin
					bad = 1'b1;
				end else begin
					stat_wd.elapsed_sum = stat_rd.elapsed_sum + (req.event_time - stamp_rd);
				end
				stat_wd.stop_count = tsb_pkg::sat_inc(stat_rd.stop_count);
				stat_wd.last_kind  = tsb_pkg::KIND_STOP;
			end
			tsb_pkg::KIND_CLEAR: begin
				stat_wd.elapsed_sum = 64'd0;
				stat_wd.clear_count = tsb_pkg::sat_inc(stat_rd.clear_count);
				stat_wd.last_kind   = tsb_pkg::KIND_CLEAR;
			end
			default: begin
			end
		endcase
		if (bad) begin
			stat_wd.misorder_count = tsb_pkg::sat_inc(stat_rd.misorder_count);
		end
	end

	assign stat_we  = in_range && (req.cmd != tsb_pkg::KIND_NONE);
	assign stamp_we = in_range && stamp_take;

	always_comb begin
		rsp            = '0;
		rsp.timer_echo = req.timer_id;
		if (in_range) begin
			rsp.out_of_order       = bad;
			rsp.total_time         = stat_wd.elapsed_sum;
			rsp.bad_sequence_total = stat_wd.misorder_count;
			rsp.start_total        = stat_wd.start_count;
			rsp.stop_total         = stat_wd.stop_count;
			rsp.clear_total        = stat_wd.clear_count;
		end
	end

endmodule

// ===== hdl/tsb_bank.sv =====
// tsb_bank: per-timer statistics and start-stamp memories, write-first read bypass,
// and the clearing sweep after reset; depends on tsb_pkg
`timescale 1ns / 1ps

module tsb_bank #(
	parameter int NUM_TIMERS = 64,
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [AW-1:0]      rd_addr,
	input  logic               stat_we,
	input  logic               stamp_we,
	input  logic [AW-1:0]      wr_addr,
	input  tsb_pkg::tsb_stat_t stat_wd,
	input  logic [63:0]        stamp_wd,
	output tsb_pkg::tsb_stat_t stat_rd,
	output logic [63:0]        stamp_rd,
	output logic               clearing
);

	tsb_pkg::tsb_stat_t stat_mem [NUM_TIMERS];
	logic [63:0]        stamp_mem [NUM_TIMERS];

	tsb_pkg::tsb_stat_t stat_rd_q;
	logic [63:0]        stamp_rd_q;
	logic               clearing_q;
	logic [AW-1:0]      clr_addr_q;

	logic               st_we;
	logic [AW-1:0]      st_wa;
	tsb_pkg::tsb_stat_t st_wd;

	// sweep the statistics memory once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(NUM_TIMERS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
		end
	end

	always_comb begin
		if (clearing_q) begin
			st_we = 1'b1;
			st_wa = clr_addr_q;
			st_wd = tsb_pkg::STAT_RESET;
		end else begin
			st_we = stat_we;
			st_wa = wr_addr;
			st_wd = stat_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			stat_mem[st_wa] <= st_wd;
		end
		stat_rd_q <= (st_we && (st_wa == rd_addr)) ? st_wd : stat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[wr_addr] <= stamp_wd;
		end
		stamp_rd_q <= (stamp_we && (wr_addr == rd_addr)) ? stamp_wd : stamp_mem[rd_addr];
	end

	assign stat_rd  = stat_rd_q;
	assign stamp_rd = stamp_rd_q;
	assign clearing = clearing_q;

endmodule

// ===== hdl/indexed_start_stop_timer_bank.sv =====
// indexed_start_stop_timer_bank: top level, request/result stages around the timer memories
// depends on tsb_pkg, tsb_bank, tsb_update
//
//   channel   handshake          payload     direction
//   request   start / busy       request     in
//   result    done (strobe)      result      out
//
// one request per cycle while busy is low; done follows the request through the stage-1 and stage-2 registers
// stage 1: memory read of the timer entry, stage 2: update, write back, result register
// a same-timer request right behind another sees the fresh entry through the read bypass
// after reset busy stays high while the statistics memory is swept
// the receiver cannot stall; results are never held back
`timescale 1ns / 1ps

module indexed_start_stop_timer_bank #(
	parameter int NUM_TIMERS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tsb_pkg::tsb_req_t request,
	output logic              done,
	output tsb_pkg::tsb_rsp_t result
);

	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int IW = ((AW > 6) ? AW : 6) + 1;

	logic               accept;
	logic [IW-1:0]      id_ext;
	logic [AW-1:0]      addr;
	logic               in_range;

	logic               v_s1;
	tsb_pkg::tsb_req_t  req_s1;
	logic               inr_s1;
	logic [AW-1:0]      addr_s1;

	logic               done_s2;
	tsb_pkg::tsb_rsp_t  rsp_s2;

	tsb_pkg::tsb_stat_t stat_rd;
	logic [63:0]        stamp_rd;
	logic               clearing;
	logic               upd_stat_we;
	logic               upd_stamp_we;
	tsb_pkg::tsb_stat_t upd_stat_wd;
	tsb_pkg::tsb_rsp_t  upd_rsp;

	assign busy     = clearing;
	assign accept   = start && !clearing;
	assign id_ext   = IW'(request.timer_id);
	assign addr     = id_ext[AW-1:0];
	assign in_range = id_ext < IW'(NUM_TIMERS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			v_s1    <= accept;
			done_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= request;
			inr_s1  <= in_range;
			addr_s1 <= addr;
		end
		if (v_s1) begin
			rsp_s2 <= upd_rsp;
		end
	end

	tsb_bank #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (addr),
		.stat_we  (v_s1 && upd_stat_we),
		.stamp_we (v_s1 && upd_stamp_we),
		.wr_addr  (addr_s1),
		.stat_wd  (upd_stat_wd),
		.stamp_wd (req_s1.event_time),
		.stat_rd  (stat_rd),
		.stamp_rd (stamp_rd),
		.clearing (clearing)
	);

	tsb_update u_update (
		.req      (req_s1),
		.in_range (inr_s1),
		.stat_rd  (stat_rd),
		.stamp_rd (stamp_rd),
		.stat_we  (upd_stat_we),
		.stat_wd  (upd_stat_wd),
		.stamp_we (upd_stamp_we),
		.rsp      (upd_rsp)
	);

	assign done   = done_s2;
	assign result = rsp_s2;

`ifndef SYNTHESIS
	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a request two cycles earlier");

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!v_s1 && !done))
		else $error("request in flight during the clearing sweep");

	a_echo_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.timer_echo == $past(request.timer_id, 2)))
		else $error("result echoes the wrong timer");

	a_misorder_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_of_order) |->
			($past(request.cmd, 2) == tsb_pkg::KIND_START ||
			 $past(request.cmd, 2) == tsb_pkg::KIND_STOP))
		else $error("missequence flagged on a clear or undefined request");
`endif

endmodule
